// ===== design/wpp_pkg.sv =====
// shared types and constants for the wav pcm header parser
package wpp_pkg;

    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [15:0] FMT_PCM  = 16'h0001;
    localparam logic [15:0] FMT_EXT  = 16'hfffe;
    localparam logic [31:0] EXT_MIN_LEN = 32'd40;
    localparam logic [15:0] EXT_MIN_CB  = 16'd22;
    localparam logic [31:0] GUID_START  = 32'd24;
    localparam int DIV_STEPS = 32;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MAGIC     = 3'd1;
    localparam logic [2:0] ST_TRUNC     = 3'd2;
    localparam logic [2:0] ST_UNSUP     = 3'd3;
    localparam logic [2:0] ST_MISSING   = 3'd4;

    localparam logic [2:0] PH_RIFF = 3'd0;
    localparam logic [2:0] PH_CHDR = 3'd1;
    localparam logic [2:0] PH_BODY = 3'd2;
    localparam logic [2:0] PH_PAD  = 3'd3;
    localparam logic [2:0] PH_HALT = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic take;      // consume one byte
        logic fin;       // after the last byte, capture status precheck and start division
        logic div_step;  // one restoring division step
        logic clear;     // result delivered, back to reset state
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_needed;
    } t_sts;

    function automatic logic [7:0] magic_byte(input logic [3:0] p);
        case (p)
            4'd0: magic_byte = 8'h52;
            4'd1: magic_byte = 8'h49;
            4'd2: magic_byte = 8'h46;
            4'd3: magic_byte = 8'h46;
            4'd8: magic_byte = 8'h57;
            4'd9: magic_byte = 8'h41;
            4'd10: magic_byte = 8'h56;
            4'd11: magic_byte = 8'h45;
            default: magic_byte = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] guid_byte(input logic [3:0] i);
        case (i)
            4'd0: guid_byte = 8'h01;
            4'd6: guid_byte = 8'h10;
            4'd8: guid_byte = 8'h80;
            4'd11: guid_byte = 8'haa;
            4'd13: guid_byte = 8'h38;
            4'd14: guid_byte = 8'h9b;
            4'd15: guid_byte = 8'h71;
            default: guid_byte = 8'h00;
        endcase
    endfunction

endpackage

// ===== design/wpp_ctrl.sv =====
// controller: accept, finish, divide, deliver
module wpp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  wpp_pkg::t_sts  i_sts,
    output wpp_pkg::t_cmd  o_cmd
);
    import wpp_pkg::*;

    typedef enum logic [3:0] {
        S_RUN  = 4'b0001,
        S_FIN  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic       acc;

    assign o_in_ready  = (r_state == S_RUN);
    assign o_out_valid = (r_state == S_OUT);
    assign acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        o_cmd = '0;
        unique case (r_state)
            S_RUN: begin
                o_cmd.take = acc;
                if (acc && i_in_last) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_cnt = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!i_sts.div_needed || r_cnt == 6'(DIV_STEPS)) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    o_cmd.clear = 1'b1;
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
        end
    end
endmodule

// ===== design/wpp_dp.sv =====
// datapath: chunk walker, fmt capture, final checks and modulo unit
module wpp_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    input  wpp_pkg::t_cmd  i_cmd,
    output wpp_pkg::t_sts  o_sts,
    output logic [2:0]     o_status,
    output logic [15:0]    o_ch,
    output logic [31:0]    o_rate,
    output logic [15:0]    o_bits,
    output logic [15:0]    o_ba,
    output logic [31:0]    o_doff,
    output logic [31:0]    o_dlen
);
    import wpp_pkg::*;

    logic [31:0] r_pos, r_tag, r_len, r_rem;
    logic [2:0]  r_ph, r_err;
    logic [63:0] r_s0, r_s1;
    logic        r_guid, r_have;
    logic [47:0] r_af0;
    logic [31:0] r_af1;
    logic [31:0] r_doff, r_dlen;
    // final check registers
    logic [2:0]  r_st;
    logic [31:0] r_rm;
    logic [31:0] r_q;

    logic [31:0] n_pos, n_tag, n_len, n_rem;
    logic [2:0]  n_ph, n_err;
    logic [63:0] n_s0, n_s1;
    logic        n_guid, n_have;
    logic [47:0] n_af0;
    logic [31:0] n_af1;
    logic [31:0] n_doff, n_dlen;

    logic [31:0] off, nr;
    logic [2:0]  k;
    logic [2:0]  s1_idx;
    logic        endb;
    logic [15:0] ftag, cb;

    always_comb begin
        n_pos = r_pos; n_tag = r_tag; n_len = r_len; n_rem = r_rem;
        n_ph = r_ph; n_err = r_err; n_s0 = r_s0; n_s1 = r_s1;
        n_guid = r_guid; n_have = r_have; n_af0 = r_af0; n_af1 = r_af1;
        n_doff = r_doff; n_dlen = r_dlen;
        endb = 1'b0;
        k = r_rem[2:0];
        off = r_len - r_rem;
        s1_idx = 3'(off - 32'd12);
        nr = r_rem - 32'd1;
        if (r_err == ST_OK) begin
            unique case (r_ph)
                PH_RIFF: begin
                    if ((r_pos < 32'd4 || r_pos >= 32'd8) && r_pos < 32'd12 &&
                        i_byte != magic_byte(r_pos[3:0])) begin
                        n_err = ST_MAGIC; n_ph = PH_HALT;
                    end else if (r_pos >= 32'd11) begin
                        n_ph = PH_CHDR; n_rem = '0; n_tag = '0; n_len = '0;
                    end
                end
                PH_CHDR: begin
                    if (!k[2]) n_tag[8*k[1:0] +: 8] = i_byte;
                    else       n_len[8*k[1:0] +: 8] = i_byte;
                    n_rem = {29'd0, k} + 32'd1;
                    if (k == 3'd7) begin
                        if (n_tag == TAG_FMT) begin
                            n_s0 = '0; n_s1 = '0; n_guid = 1'b1;
                        end else if (n_tag == TAG_DATA) begin
                            n_doff = r_pos + 32'd1; n_dlen = n_len;
                        end
                        n_rem = n_len;
                        if (n_len == 32'd0) endb = 1'b1;
                        else n_ph = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (r_tag == TAG_FMT) begin
                        if (off < 32'd8) n_s0[8*off[2:0] +: 8] = i_byte;
                        else if (off >= 32'd12 && off < 32'd18)
                            n_s1[8*s1_idx +: 8] = i_byte;
                        else if (off >= GUID_START && off < 32'd40 &&
                                 i_byte != guid_byte(4'(off - GUID_START)))
                            n_guid = 1'b0;
                    end
                    n_rem = nr;
                    if (nr == 32'd0) endb = 1'b1;
                end
                PH_PAD: begin
                    n_ph = PH_CHDR; n_rem = '0; n_tag = '0; n_len = '0;
                end
                default: ;
            endcase
            // format fields include the byte taken this cycle
            ftag = n_s0[15:0];
            cb = n_s1[47:32];
            if (endb) begin
                // tag and length here are the current chunk's, after header update
                if (n_tag == TAG_FMT && (n_len < 32'd16 || !(ftag == FMT_PCM ||
                    (ftag == FMT_EXT && n_len >= EXT_MIN_LEN && cb >= EXT_MIN_CB &&
                     n_guid)))) begin
                    n_err = ST_UNSUP; n_ph = PH_HALT;
                end else begin
                    if (n_tag == TAG_FMT) begin
                        n_af0 = n_s0[63:16]; n_af1 = n_s1[31:0]; n_have = 1'b1;
                    end
                    if (n_len[0]) n_ph = PH_PAD;
                    else begin
                        n_ph = PH_CHDR; n_rem = '0; n_tag = '0; n_len = '0;
                    end
                end
            end
            if (n_err == ST_OK && r_pos == 32'hffff_ffff && !i_last) begin
                n_err = ST_TRUNC; n_ph = PH_HALT;
            end
        end else begin
            ftag = n_s0[15:0];
            cb = n_s1[47:32];
        end
        n_pos = r_pos + 32'd1;
    end

    logic [15:0] ch, bits, ba;
    logic [31:0] rate;
    logic [17:0] expct;
    logic [2:0]  pre;
    logic [32:0] trial;
    assign ch = r_af0[15:0];
    assign rate = r_af0[47:16];
    assign ba = r_af1[15:0];
    assign bits = r_af1[31:16];
    assign expct = (bits == 16'd24) ? ({2'd0, ch} + {1'b0, ch, 1'b0}) : {1'b0, ch, 1'b0};
    assign trial = {r_rm, r_q[31]} - {17'd0, ba};

    always_comb begin
        pre = r_err;
        if (pre == ST_OK && r_ph == PH_RIFF) pre = ST_MAGIC;
        else if (pre == ST_OK && r_ph == PH_BODY) pre = ST_TRUNC;
        if (pre == ST_OK && (!r_have || r_dlen == 32'd0)) pre = ST_MISSING;
        if (pre == ST_OK && (ch == 16'd0 || rate == 32'd0 ||
            (bits != 16'd16 && bits != 16'd24) || ba == 16'd0 ||
            {2'd0, ba} != expct)) pre = ST_UNSUP;
    end

    assign o_sts.div_needed = (r_st == ST_OK);
    assign o_status = (r_st == ST_OK && r_rm != 32'd0) ? ST_UNSUP : r_st;
    assign o_ch   = (o_status == ST_OK) ? ch : '0;
    assign o_rate = (o_status == ST_OK) ? rate : '0;
    assign o_bits = (o_status == ST_OK) ? bits : '0;
    assign o_ba   = (o_status == ST_OK) ? ba : '0;
    assign o_doff = (o_status == ST_OK) ? r_doff : '0;
    assign o_dlen = (o_status == ST_OK) ? r_dlen : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_st <= pre; r_rm <= '0; r_q <= r_dlen;
        end else if (i_cmd.div_step) begin
            r_q <= {r_q[30:0], 1'b0};
            if (!trial[32]) r_rm <= trial[31:0];
            else r_rm <= {r_rm[30:0], r_q[31]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_pos <= '0; r_tag <= '0; r_len <= '0; r_rem <= '0;
            r_ph <= PH_RIFF; r_err <= ST_OK; r_s0 <= '0; r_s1 <= '0;
            r_guid <= 1'b1; r_have <= 1'b0; r_af0 <= '0; r_af1 <= '0;
            r_doff <= '0; r_dlen <= '0;
        end else if (i_cmd.take) begin
            r_pos <= n_pos; r_tag <= n_tag; r_len <= n_len; r_rem <= n_rem;
            r_ph <= n_ph; r_err <= n_err; r_s0 <= n_s0; r_s1 <= n_s1;
            r_guid <= n_guid; r_have <= n_have; r_af0 <= n_af0; r_af1 <= n_af1;
            r_doff <= n_doff; r_dlen <= n_dlen;
        end
    end
endmodule

// ===== design/wav_pcm_header_parser_core.sv =====
// top level of the wav pcm header parser
//
// input stream: one file byte per transaction on s_axis_tdata, s_axis_tlast
// marks the final byte of the file. bytes are taken at one per cycle while
// the file streams in; the chunk walker updates all state as each byte is
// taken. after the last byte the block stops accepting: a finish state forms
// the status, then a restoring divider checks data length modulo block align,
// one bit per cycle (skipped when the status is already an error). the result
// transaction then sits on m_axis until taken, and the next file starts the
// cycle after the result is taken.
// output tdata carries status and the format fields; all fields but status
// are zero unless status is ok.
// reset (synchronous, active low) returns the parser to the riff header phase
// with no result pending. a stalled receiver simply holds the result and
// the input side stays blocked.
module wav_pcm_header_parser_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // file_byte
    input  logic         s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], channel_count[18:3], sample_rate_hz[50:19], sample_bits[66:51],
    // frame_bytes[82:67], data_offset[114:83], data_length[146:115], zero pad to 152
    output logic [151:0] m_axis_tdata
);
    import wpp_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic [2:0]  status;
    logic [15:0] ch, bits, ba;
    logic [31:0] rate, doff, dlen;

    // controller owns handshakes and sequencing
    wpp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_last(s_axis_tlast),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready), .i_sts(sts), .o_cmd(cmd)
    );

    // datapath holds parser state and the modulo unit
    wpp_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_byte(s_axis_tdata), .i_last(s_axis_tlast),
        .i_cmd(cmd), .o_sts(sts),
        .o_status(status), .o_ch(ch), .o_rate(rate), .o_bits(bits),
        .o_ba(ba), .o_doff(doff), .o_dlen(dlen)
    );

    assign m_axis_tdata = {5'd0, dlen, doff, ba, bits, rate, ch, status};
endmodule

// ===== design/wpp_checker.sv =====
// port-level checker bound to the top level
module wpp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tlast,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [151:0] m_axis_tdata
);
    import wpp_pkg::*;

    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // no input while a result is pending
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted with result pending");
    // last byte closes input
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input open after last byte");
    // non-ok status carries zero fields
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != ST_OK |-> m_axis_tdata[151:3] == '0)
        else $error("fields nonzero on error status");
endmodule

bind wav_pcm_header_parser_core wpp_checker u_wpp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tlast(s_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

// ===== sim/tb.sv =====
// testbench for the wav pcm header parser: wav files byte by byte, results checked against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wpp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;   // file_byte
    logic         s_axis_tlast;   // last_byte
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // status, channel_count, sample_rate_hz, sample_bits, frame_bytes, data_offset, data_length
    logic [151:0] m_axis_tdata;

    wav_pcm_header_parser_core dut (.*);

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [15:0] frame;
        logic [31:0] offset;
        logic [31:0] length;
    } t_report;

    t_report     report_q[$];
    logic [7:0]  file_q[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          quiet = 0;
    int          hold_req = 0;
    int          bytes_sent = 0;
    int          files_sent = 0;

    // parser state mirror
    logic [31:0] p_pos;
    logic [2:0]  p_phase;
    logic [31:0] p_tag;
    logic [31:0] p_len;
    logic [31:0] p_rem;
    logic [63:0] p_fmt0, p_fmt1;
    logic        p_guid_ok;
    logic [63:0] p_acc0, p_acc1;
    logic        p_have_fmt;
    logic [63:0] p_data_loc;
    logic [2:0]  p_err;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [7:0] riff_magic(input int p);
        logic [7:0] m[12];
        m = '{8'h52, 8'h49, 8'h46, 8'h46, 0, 0, 0, 0, 8'h57, 8'h41, 8'h56, 8'h45};
        return m[p];
    endfunction

    function automatic logic [7:0] subformat_byte(input int i);
        logic [7:0] g[16];
        g = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00,
              8'h80, 8'h00, 8'h00, 8'haa, 8'h00, 8'h38, 8'h9b, 8'h71};
        return g[i];
    endfunction

    task automatic parser_clear();
        p_pos = 0; p_phase = PH_RIFF; p_tag = 0; p_len = 0; p_rem = 0;
        p_fmt0 = 0; p_fmt1 = 0; p_guid_ok = 1; p_acc0 = 0; p_acc1 = 0;
        p_have_fmt = 0; p_data_loc = 0; p_err = ST_OK;
    endtask

    task automatic latch_error(input logic [2:0] code);
        if (p_err == ST_OK) p_err = code;
        p_phase = PH_HALT;
    endtask

    task automatic next_header();
        p_phase = PH_CHDR; p_rem = 0; p_tag = 0; p_len = 0;
    endtask

    // end of a chunk body: fmt validation, then pad or next header
    task automatic close_body();
        logic [15:0] ftag, cb;
        logic classic, ext;
        if (p_tag == TAG_FMT) begin
            ftag = p_fmt0[15:0];
            cb = p_fmt1[47:32];
            classic = ftag == FMT_PCM;
            ext = ftag == FMT_EXT && p_len >= EXT_MIN_LEN && cb >= EXT_MIN_CB && p_guid_ok;
            if (p_len < 16 || (!classic && !ext)) begin
                latch_error(ST_UNSUP);
                return;
            end
            p_acc0 = {16'h0, p_fmt0[63:32], p_fmt0[31:16]};
            p_acc1 = {32'h0, p_fmt1[31:16], p_fmt1[15:0]};
            p_have_fmt = 1;
        end
        if (p_len[0]) p_phase = PH_PAD;
        else next_header();
    endtask

    task automatic walk_byte(input logic [7:0] b, input logic [31:0] pos);
        logic [31:0] k, o;
        case (p_phase)
            PH_RIFF: begin
                if ((pos < 4 || pos >= 8) && pos < 12 && b != riff_magic(pos)) begin
                    latch_error(ST_MAGIC);
                    return;
                end
                if (pos >= 11) next_header();
            end
            PH_CHDR: begin
                k = p_rem & 7;
                if (k < 4) p_tag |= 32'(b) << (8 * k);
                else p_len |= 32'(b) << (8 * (k - 4));
                p_rem = k + 1;
                if (p_rem == 8) begin
                    if (p_tag == TAG_FMT) begin
                        p_fmt0 = 0; p_fmt1 = 0; p_guid_ok = 1;
                    end else if (p_tag == TAG_DATA) begin
                        p_data_loc = {p_len, pos + 32'd1};
                    end
                    p_rem = p_len;
                    if (p_rem == 0) close_body();
                    else p_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                o = p_len - p_rem;
                if (p_tag == TAG_FMT) begin
                    if (o < 8) p_fmt0 |= 64'(b) << (8 * o);
                    else if (o >= 12 && o < 18) p_fmt1 |= 64'(b) << (8 * (o - 12));
                    else if (o >= 24 && o < 40 && b != subformat_byte(o - 24)) p_guid_ok = 0;
                end
                p_rem = p_rem - 1;
                if (p_rem == 0) close_body();
            end
            PH_PAD: next_header();
            default: ;
        endcase
    endtask

    // advance the mirror by one accepted byte, queue a report on the last byte
    task automatic predict_byte(input logic [7:0] b, input logic last);
        logic [31:0] pos, rate, dlen, need;
        logic [15:0] ch, ba, bits;
        t_report r;
        pos = p_pos;
        if (p_err == ST_OK) walk_byte(b, pos);
        if (p_err == ST_OK && pos == 32'hffff_ffff && !last) latch_error(ST_TRUNC);
        p_pos = pos + 1;
        if (!last) return;
        r = '0;
        r.status = p_err;
        if (r.status == ST_OK) begin
            if (p_phase == PH_RIFF) r.status = ST_MAGIC;
            else if (p_phase == PH_BODY) r.status = ST_TRUNC;
        end
        ch = p_acc0[15:0]; rate = p_acc0[47:16];
        ba = p_acc1[15:0]; bits = p_acc1[31:16];
        dlen = p_data_loc[63:32];
        if (r.status == ST_OK && (!p_have_fmt || dlen == 0)) r.status = ST_MISSING;
        if (r.status == ST_OK) begin
            need = 32'(ch) * ((32'(bits) + 7) / 8);
            if (ch == 0 || rate == 0 || (bits != 16 && bits != 24) || ba == 0 ||
                32'(ba) != need || (dlen % 32'(ba)) != 0)
                r.status = ST_UNSUP;
        end
        if (r.status == ST_OK) begin
            r.channels = ch; r.rate = rate; r.bits = bits; r.frame = ba;
            r.offset = p_data_loc[31:0]; r.length = dlen;
        end
        report_q.push_back(r);
        parser_clear();
    endtask

    // one byte transaction, with random gaps before it
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
        file_q.delete();
        files_sent++;
    endtask

    task automatic put16(input logic [15:0] v);
        file_q.push_back(v[7:0]); file_q.push_back(v[15:8]);
    endtask

    task automatic put32(input logic [31:0] v);
        put16(v[15:0]); put16(v[31:16]);
    endtask

    task automatic put_riff();
        put32(32'h4646_4952); put32($urandom); put32(32'h4556_4157);
    endtask

    // fmt chunk built in an array, then copied; ext selects the extensible layout
    task automatic put_fmt_body(input bit ext, input logic [15:0] ch, input logic [31:0] rate,
                                input logic [15:0] ba, input logic [15:0] bits,
                                input logic [31:0] len, input logic [15:0] cb, input bit guid_ok);
        logic [7:0] body[$];
        logic [31:0] brate;
        brate = rate * ba;
        body = {ext ? 8'hfe : 8'h01, ext ? 8'hff : 8'h00, ch[7:0], ch[15:8],
                rate[7:0], rate[15:8], rate[23:16], rate[31:24],
                brate[7:0], brate[15:8], brate[23:16], brate[31:24],
                ba[7:0], ba[15:8], bits[7:0], bits[15:8], cb[7:0], cb[15:8]};
        for (int o = 18; o < 24; o++) body.push_back(8'($urandom));
        for (int o = 24; o < 40; o++)
            body.push_back(guid_ok || o != 35 ? subformat_byte(o - 24) : 8'h55);
        while (body.size() < len) body.push_back(8'($urandom));
        put32(TAG_FMT); put32(len);
        for (int i = 0; i < len; i++) file_q.push_back(body[i]);
        if (len[0]) file_q.push_back(8'($urandom));
    endtask

    task automatic put_chunk(input logic [31:0] tag, input logic [31:0] len, input bit pad);
        put32(tag); put32(len);
        repeat (len) file_q.push_back(8'($urandom));
        if (len[0] && pad) file_q.push_back(8'($urandom));
    endtask

    task automatic put_classic(input logic [15:0] ch, input logic [15:0] bits);
        put_fmt_body(0, ch, 48000, ch * (bits / 8), bits, 16, 0, 1);
    endtask

    task automatic test_directed();
        file_q = {8'h52}; send_file();                         // one-byte file
        put_riff(); void'(file_q.pop_back()); send_file();     // eleven bytes
        put_riff(); file_q[9] = 8'h00; put_classic(2, 16); put_chunk(TAG_DATA, 8, 1); send_file();
        put_riff(); file_q[0] = 8'hff; send_file();            // bad riff tag
        put_riff(); put_classic(2, 16); put_chunk(TAG_DATA, 8, 1); send_file();
        put_riff(); put_classic(3, 24); put_chunk(TAG_DATA, 9, 1); send_file();
        put_riff(); put_fmt_body(1, 1, 44100, 2, 16, 40, 22, 1); put_chunk(TAG_DATA, 6, 1);
        send_file();
        put_riff(); put_fmt_body(1, 1, 44100, 2, 16, 40, 22, 0); put_chunk(TAG_DATA, 6, 1);
        send_file();                                           // guid mismatch
        put_riff(); put_fmt_body(1, 1, 44100, 2, 16, 40, 21, 1); put_chunk(TAG_DATA, 6, 1);
        send_file();                                           // cbsize too small
        put_riff(); put_fmt_body(1, 1, 44100, 2, 16, 38, 22, 1); put_chunk(TAG_DATA, 6, 1);
        send_file();                                           // extensible too short
        put_riff(); put_fmt_body(0, 1, 8000, 2, 16, 14, 0, 1); put_chunk(TAG_DATA, 6, 1);
        send_file();                                           // fmt below 16 bytes
        put_riff(); put_fmt_body(0, 1, 8000, 2, 16, 18, 0, 1); put_chunk(TAG_DATA, 4, 1);
        void'(file_q.pop_back()); send_file();                 // data body cut off
        put_riff(); put_chunk(TAG_DATA, 4, 1); send_file();    // no fmt
        put_riff(); put_classic(1, 16); put_chunk(TAG_DATA, 0, 1); send_file(); // empty data
        put_riff(); put_classic(1, 8); put_chunk(TAG_DATA, 4, 1); send_file();  // 8 bits
        put_riff(); put_fmt_body(0, 2, 8000, 3, 16, 16, 0, 1); put_chunk(TAG_DATA, 6, 1);
        send_file();                                           // block align mismatch
        put_riff(); put_classic(2, 16); put_chunk(TAG_DATA, 6, 1); send_file(); // length mod
        put_riff(); put_fmt_body(0, 0, 8000, 0, 16, 16, 0, 1); put_chunk(TAG_DATA, 4, 1);
        send_file();                                           // zero channels
        put_riff(); put_fmt_body(0, 1, 0, 2, 16, 16, 0, 1); put_chunk(TAG_DATA, 4, 1);
        send_file();                                           // zero rate
        put_riff(); put_fmt_body(0, 16'hffff, 32'hffff_ffff, 16'hfffe, 16, 16, 0, 1);
        put_chunk(TAG_DATA, 4, 1); send_file();                // field extremes
        put_riff(); put_chunk(TAG_DATA, 3, 1); put_classic(1, 24); put_classic(2, 16);
        put_chunk(32'h6b6e_756a, 5, 1); put_chunk(TAG_DATA, 4, 1); put_chunk(32'h0, 0, 1);
        put32(TAG_DATA); send_file();                          // last fmt and data win, partial header
        put_riff(); put_classic(1, 16); put_chunk(TAG_DATA, 3, 0); send_file(); // missing pad
    endtask

    task automatic random_file();
        int k, bits, ch, ba, dlen;
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 20)) file_q.push_back(8'($urandom));
            return;
        end
        put_riff();
        k = $urandom_range(0, 5);
        bits = k < 2 ? 16 : k < 4 ? 24 : k == 4 ? 8 : $urandom_range(0, 65535);
        ch = $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535) : $urandom_range(1, 3);
        ba = $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535) : ch * ((bits + 7) / 8);
        if ($urandom_range(0, 2) == 0) put_chunk($urandom, $urandom_range(0, 7), 1);
        if ($urandom_range(0, 1))
            put_fmt_body(0, ch, $urandom, ba, bits, $urandom_range(0, 7) == 0 ? 14 :
                         $urandom_range(0, 1) ? 16 : 18, $urandom, 1);
        else
            put_fmt_body(1, ch, $urandom, ba, bits, $urandom_range(0, 7) == 0 ? 38 : 40,
                         $urandom_range(0, 7) == 0 ? 16 : 22 + $urandom_range(0, 3),
                         $urandom_range(0, 7) != 0);
        if ($urandom_range(0, 3) == 0) put_chunk($urandom, $urandom_range(0, 5), 1);
        dlen = (ba % 12) * $urandom_range(0, 3);
        if ($urandom_range(0, 7) == 0) dlen = dlen + 1;
        if ($urandom_range(0, 15) != 0) put_chunk(TAG_DATA, dlen, $urandom_range(0, 3) != 0);
        if ($urandom_range(0, 6) == 0)
            file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom);
        if ($urandom_range(0, 9) == 0 && file_q.size() > 1)
            repeat ($urandom_range(1, file_q.size() - 1)) void'(file_q.pop_back());
    endtask

    task automatic test_random(input int byte_goal, input int file_goal);
        int b0, f0;
        b0 = bytes_sent; f0 = files_sent;
        while (bytes_sent - b0 < byte_goal || files_sent - f0 < file_goal) begin
            random_file();
            send_file();
        end
    endtask

    // receiver blocks for a long stretch while files keep coming
    task automatic test_backpressure();
        hold_req++;
        test_random(100, 2);
    endtask

    task automatic test_no_idle();
        quiet = 1;
        test_random(200, 3);
    endtask

    // receiver ready with random bursts and a requested long hold-off
    initial begin
        int gap, hold, seen;
        gap = 0; hold = 0; seen = 0;
        m_axis_tready = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req != seen) begin
                seen = hold_req;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 0;
            end else if (gap > 0) begin
                gap--;
                m_axis_tready <= 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(0, 3);
                m_axis_tready <= 0;
            end else begin
                m_axis_tready <= 1;
            end
        end
    end

    // compare every result transaction with the oldest expected report
    always @(posedge i_clk) begin
        t_report got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{status: m_axis_tdata[2:0], channels: m_axis_tdata[18:3],
                    rate: m_axis_tdata[50:19], bits: m_axis_tdata[66:51],
                    frame: m_axis_tdata[82:67], offset: m_axis_tdata[114:83],
                    length: m_axis_tdata[146:115]};
            if (report_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = report_q.pop_front();
                if (got.status != want.status || got.channels != want.channels ||
                    got.rate != want.rate || got.bits != want.bits ||
                    got.frame != want.frame || got.offset != want.offset ||
                    got.length != want.length || m_axis_tdata[151:147] != 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    initial begin
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tlast = 0;
        parser_clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_random(250, 3);
        test_backpressure();
        test_no_idle();
        s_axis_tvalid <= 0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && report_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
